// ===== rtl/text_mode_pixel_generator_defines.svh =====
// assertion macros for the text mode pixel generator
`ifndef TEXT_MODE_PIXEL_GENERATOR_DEFINES_SVH
`define TEXT_MODE_PIXEL_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define TMPG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked during reset as well
`define TMPG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMPG_ASSERT(name, prop, msg)
`define TMPG_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== rtl/tmpg_pkg.sv =====
`default_nettype none

package tmpg_pkg;

  // command word codes
  localparam logic [1:0] MODE_SCREEN = 2'd0;
  localparam logic [1:0] MODE_COLOUR = 2'd1;
  localparam logic [1:0] MODE_GLYPH  = 2'd2;
  localparam logic [1:0] MODE_RENDER = 2'd3;

  // fixed store depths for cell data
  localparam int CELL_DEPTH = 512;
  localparam int CELL_AW    = 9;
  localparam int OFFSET_W   = 12;

  typedef struct packed {
    logic [1:0]  mode;
    logic [10:0] address;
    logic [7:0]  write_data;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_word_t;

  // fixed 16-entry rgb palette
  function automatic pixel_word_t palette_rgb(input logic [3:0] idx);
    pixel_word_t c;
    case (idx)
      4'd0:    c = '{8'h00, 8'h00, 8'h00};
      4'd1:    c = '{8'hFF, 8'hFF, 8'hFF};
      4'd2:    c = '{8'h68, 8'h37, 8'h2B};
      4'd3:    c = '{8'h70, 8'hA4, 8'hB2};
      4'd4:    c = '{8'h6F, 8'h3D, 8'h86};
      4'd5:    c = '{8'h58, 8'h8D, 8'h43};
      4'd6:    c = '{8'h35, 8'h28, 8'h79};
      4'd7:    c = '{8'hB8, 8'hC7, 8'h6F};
      4'd8:    c = '{8'h6F, 8'h4F, 8'h25};
      4'd9:    c = '{8'h43, 8'h39, 8'h00};
      4'd10:   c = '{8'h9A, 8'h67, 8'h59};
      4'd11:   c = '{8'h44, 8'h44, 8'h44};
      4'd12:   c = '{8'h6C, 8'h6C, 8'h6C};
      4'd13:   c = '{8'h9A, 8'hD2, 8'h84};
      4'd14:   c = '{8'h6C, 8'h5E, 8'hB5};
      default: c = '{8'h95, 8'h95, 8'h95};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/text_mode_pixel_generator.sv =====
// Character-mode pixel generator.
// cmd channel (cmd_valid/cmd_stall/cmd): one word per accepted edge. Modes
// screen, colour and glyph write one byte (colour keeps its low four bits)
// into the screen code, cell colour or glyph row memory at the accept edge
// and give no pixel. Render looks up (pixel_x, pixel_y) and gives one word.
// pixel channel (pixel_valid/pixel_stall/pixel): rgb of the rendered pixel.
// cfg channel (cfg_valid/cfg_ready/cfg_data): background colour index,
// always ready; the user must write it only while the block is idle.
// The block itself does not enforce this. A render word passes these
// registered steps in order: cell memories read at the accept edge, glyph
// memory read, palette into output register. Write words do not raise
// cmd_stall; a render word holds it high until its pixel is loaded, and
// the next word is accepted once the pixel is loaded.
// When pixel_stall holds the output register full, a finished render waits
// in its last step and cmd_stall stays high; write words are still taken
// while only the output register waits.
// Reset clears control state and sets the background to index 1; memories
// are not cleared and must be written before they are read.
`default_nettype none
`include "text_mode_pixel_generator_defines.svh"

module text_mode_pixel_generator #(
  parameter int SCREEN_COLUMNS = 22,
  parameter int SCREEN_ROWS    = 23,
  parameter int GLYPH_COUNT    = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_stall,
  input  wire tmpg_pkg::cmd_word_t   cmd,
  output logic                       pixel_valid,
  input  wire logic                  pixel_stall,
  output tmpg_pkg::pixel_word_t      pixel,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [3:0]            cfg_data
);
  import tmpg_pkg::*;

  localparam int GLYPH_DEPTH = GLYPH_COUNT * 8;
  localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_GLYPH = 2'd1;
  localparam logic [1:0] ST_PIX   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [3:0] background;

  logic [7:0] screen_mem [CELL_DEPTH];
  logic [3:0] colour_mem [CELL_DEPTH];
  logic [7:0] glyph_mem  [GLYPH_DEPTH];

  logic          cmd_accept;
  logic          render_accept;
  logic [4:0]    cell_col;
  logic [4:0]    cell_row;
  logic [OFFSET_W-1:0] offset;
  logic          on_screen;

  logic [7:0]    code;
  logic [3:0]    colour;
  logic [7:0]    glyph_bits;
  logic          on_screen_q;
  logic          code_ok;
  logic [2:0]    px_lo;
  logic [2:0]    py_lo;
  logic [10:0]   glyph_addr;
  logic          glyph_bit;
  logic [3:0]    pix_idx;
  logic          pix_load;

  assign cmd_stall     = (state != ST_IDLE);
  assign cmd_accept    = cmd_valid && !cmd_stall;
  assign render_accept = cmd_accept && (cmd.mode == MODE_RENDER);
  assign cfg_ready     = 1'b1;

  // background colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      background <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      background <= cfg_data;
    end
  end

  // cell position of the render coordinate
  assign cell_col  = cmd.pixel_x[7:3];
  assign cell_row  = cmd.pixel_y[7:3];
  assign offset    = OFFSET_W'(cell_row) * OFFSET_W'(SCREEN_COLUMNS) + OFFSET_W'(cell_col);
  assign on_screen = (7'(cell_col) < 7'(SCREEN_COLUMNS)) && (7'(cell_row) < 7'(SCREEN_ROWS))
                     && (offset < OFFSET_W'(CELL_DEPTH));

  // cell memories: write on a write word, read on a render accept
  always_ff @(posedge clk) begin
    if (cmd_accept && (cmd.mode == MODE_SCREEN) && (cmd.address[10:CELL_AW] == '0)) begin
      screen_mem[cmd.address[CELL_AW-1:0]] <= cmd.write_data;
    end
    if (render_accept) begin
      code <= screen_mem[offset[CELL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept && (cmd.mode == MODE_COLOUR) && (cmd.address[10:CELL_AW] == '0)) begin
      colour_mem[cmd.address[CELL_AW-1:0]] <= cmd.write_data[3:0];
    end
    if (render_accept) begin
      colour <= colour_mem[offset[CELL_AW-1:0]];
    end
  end

  // glyph memory: the read address comes from the fetched code
  assign glyph_addr = {code, py_lo};

  always_ff @(posedge clk) begin
    if (cmd_accept && (cmd.mode == MODE_GLYPH) && (12'(cmd.address) < 12'(GLYPH_DEPTH))) begin
      glyph_mem[cmd.address[GLYPH_AW-1:0]] <= cmd.write_data;
    end
    if (state == ST_GLYPH) begin
      glyph_bits <= glyph_mem[glyph_addr[GLYPH_AW-1:0]];
    end
  end

  // render context carried along the lookup
  always_ff @(posedge clk) begin
    if (render_accept) begin
      on_screen_q <= on_screen;
      px_lo       <= cmd.pixel_x[2:0];
      py_lo       <= cmd.pixel_y[2:0];
    end
    if (state == ST_GLYPH) begin
      code_ok <= (9'(code) < 9'(GLYPH_COUNT));
    end
  end

  // colour choice and palette
  assign glyph_bit = glyph_bits[3'd7 - px_lo];
  assign pix_idx   = (on_screen_q && code_ok && glyph_bit) ? colour : background;
  assign pix_load  = (state == ST_PIX) && (!pixel_valid || !pixel_stall);

  always_ff @(posedge clk) begin
    if (pix_load) begin
      pixel <= palette_rgb(pix_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (pix_load) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  // sequencer: one render word at a time, so reads never meet writes
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (render_accept) state_next = ST_GLYPH;
      end
      ST_GLYPH: begin
        state_next = ST_PIX;
      end
      ST_PIX: begin
        if (pix_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // checks
  `TMPG_ASSERT(a_render_reaches_pix, render_accept |=> ##1 (state == ST_PIX), "render lookup lost")
  `TMPG_ASSERT(a_pixel_from_pix, $rose(pixel_valid) |-> ($past(state) == ST_PIX), "pixel without render")
  `TMPG_ASSERT_ALWAYS(a_reset_state, rst |=> (state == ST_IDLE && !pixel_valid && background == 4'd1), "bad reset")

endmodule

`default_nettype wire
